[sv/ffba_pkg.sv]
// ============================================================================
// ffba_pkg - shared definitions for the first-fit block allocator
// Heap geometry, word layout, opcodes and the controller/datapath bundles.
// ============================================================================
`default_nettype none

package ffba_pkg;

    // Heap geometry, in 16-byte granules
    localparam int HEAP_GRANULES = 256;
    localparam int G_W    = $clog2(HEAP_GRANULES);      // granule index width
    localparam int SPAN_W = $clog2(HEAP_GRANULES + 1);  // block span in granules
    localparam int NXT_W  = SPAN_W + 1;                 // index + span sum
    localparam int WORD_W = SPAN_W + 1;                 // alloc bit + span

    // Request fields
    localparam int REQ_W     = 12;
    localparam int ADDR_W    = 12;
    localparam int NEED_W    = 9;       // (4088 + 8 + 15) / 16 = 256 granules
    localparam int REQ_MAX   = 4088;
    localparam int NEED_BIAS = 23;      // 8-byte header plus 15 for round-up
    localparam int FIT_W     = (SPAN_W > NEED_W) ? SPAN_W : NEED_W;
    localparam int CMP_W     = (G_W + 4 > ADDR_W) ? G_W + 4 : ADDR_W;

    // Opcodes and result codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_FAIL   = 1'b1;

    // One header word: allocated mark and size in granules
    typedef struct packed {
        logic              alloc;
        logic [SPAN_W-1:0] span;
    } t_word;

    // Controller to datapath
    typedef struct packed {
        logic take;      // latch the incoming item
        logic rd_first;  // point at granule 0 and read it
        logic scan_adv;  // step the search to the next block
        logic wr_init;   // write the single free block after reset
        logic wr_alloc;  // mark the found block allocated
        logic wr_split;  // write the free remainder header
        logic wr_free;   // clear the allocated mark
        logic m_first;   // merge walk: hold current word, read the next one
        logic m_adv;     // merge walk: slide the pair by one block
        logic wr_merge;  // join a free pair
        logic pass_set;  // first merge pass is done
        logic res_ok;    // record success
        logic res_fail;  // record failure
        logic out_load;  // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_free;   // incoming item is a free request
        logic in_big;    // incoming size is out of range
        logic is_free;   // latched item is a free request
        logic fit;       // block at r_g is free and large enough
        logic split;     // a remainder is left after the fit
        logic match;     // block at r_g has the requested user address
        logic end_g;     // no block follows r_g
        logic end_n;     // no block follows r_n
        logic both_free; // current and next block are both free
        logic pass_done; // second merge pass under way
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

[sv/ffba_req_if.sv]
// ============================================================================
// ffba_req_if - request channel
// Valid/ready channel carrying one allocate or free item.
// ============================================================================
`default_nettype none

interface ffba_req_if
    import ffba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [REQ_W-1:0]  req_size;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, action, req_size, free_addr, input ready);
    modport sink   (input valid, action, req_size, free_addr, output ready);
endinterface

`default_nettype wire

[sv/ffba_rsp_if.sv]
// ============================================================================
// ffba_rsp_if - response channel
// Valid/ready channel carrying one result item.
// ============================================================================
`default_nettype none

interface ffba_rsp_if
    import ffba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              status;
    logic [ADDR_W-1:0] user_addr;

    modport source (output valid, status, user_addr, input ready);
    modport sink   (input valid, status, user_addr, output ready);
endinterface

`default_nettype wire

[sv/ffba_ram.sv]
// ============================================================================
// ffba_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[sv/ffba_dp.sv]
// ============================================================================
// ffba_dp - allocator datapath
// Header RAM, walk pointers, fit/match/merge arithmetic and result register.
// ============================================================================
`default_nettype none

module ffba_dp
    import ffba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_action,
    input  wire logic [REQ_W-1:0]  i_req_size,
    input  wire logic [ADDR_W-1:0] i_free_addr,
    input  wire logic              i_out_ready,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    output logic                   o_status,
    output logic      [ADDR_W-1:0] o_user_addr
);

    // latched item and walk state
    logic              r_action;
    logic [NEED_W-1:0] r_need;
    logic [ADDR_W-1:0] r_addr;
    logic [G_W-1:0]    r_g;
    logic [G_W-1:0]    r_n;
    logic [G_W-1:0]    r_split;
    logic [SPAN_W-1:0] r_rest;
    t_word             r_cur;
    logic              r_pass;
    logic              r_res_status;
    logic [ADDR_W-1:0] r_res_addr;
    logic              r_out_valid;
    logic              r_out_status;
    logic [ADDR_W-1:0] r_out_addr;

    // RAM ports
    logic              ram_we;
    logic [G_W-1:0]    ram_waddr;
    t_word             ram_wdata;
    logic              ram_re;
    logic [G_W-1:0]    ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    t_word             rd;

    // arithmetic
    logic [12:0]       n_sum;
    logic [NXT_W-1:0]  next_g;
    logic [NXT_W-1:0]  next_n;
    logic [FIT_W-1:0]  rest_full;
    logic [NXT_W-1:0]  join_sum;
    logic [G_W+3:0]    addr_full;

    ffba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HEAP_GRANULES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd = t_word'(ram_rdata);

    // block walk arithmetic
    assign n_sum     = 13'(i_req_size) + 13'(NEED_BIAS);
    assign next_g    = NXT_W'(r_g) + NXT_W'(rd.span);
    assign next_n    = NXT_W'(r_n) + NXT_W'(rd.span);
    assign rest_full = FIT_W'(rd.span) - FIT_W'(r_need);
    assign join_sum  = NXT_W'(r_cur.span) + NXT_W'(rd.span);
    assign addr_full = {r_g, 4'h8};

    // status to the controller
    always_comb begin
        o_sts.in_free   = (i_action == ACT_FREE);
        o_sts.in_big    = (i_req_size > REQ_W'(REQ_MAX));
        o_sts.is_free   = (r_action == ACT_FREE);
        o_sts.fit       = !rd.alloc && (FIT_W'(rd.span) >= FIT_W'(r_need));
        o_sts.split     = (rest_full != '0);
        o_sts.match     = (CMP_W'(addr_full) == CMP_W'(r_addr));
        o_sts.end_g     = (rd.span == '0) || (next_g >= NXT_W'(HEAP_GRANULES));
        o_sts.end_n     = (rd.span == '0) || (next_n >= NXT_W'(HEAP_GRANULES));
        o_sts.both_free = !r_cur.alloc && !rd.alloc;
        o_sts.pass_done = r_pass;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // RAM write port
    always_comb begin
        ram_we    = i_cmd.wr_init | i_cmd.wr_alloc | i_cmd.wr_split
                  | i_cmd.wr_free | i_cmd.wr_merge;
        ram_waddr = r_g;
        ram_wdata = rd;
        if (i_cmd.wr_init) begin
            ram_waddr = '0;
            ram_wdata = '{alloc: 1'b0, span: SPAN_W'(HEAP_GRANULES)};
        end else if (i_cmd.wr_split) begin
            ram_waddr = r_split;
            ram_wdata = '{alloc: 1'b0, span: r_rest};
        end else if (i_cmd.wr_alloc) begin
            ram_wdata.alloc = 1'b1;
            ram_wdata.span  = (rest_full != '0) ? SPAN_W'(r_need) : rd.span;
        end else if (i_cmd.wr_free) begin
            ram_wdata.alloc = 1'b0;
        end else if (i_cmd.wr_merge) begin
            ram_wdata = '{alloc: 1'b0, span: SPAN_W'(join_sum)};
        end
    end

    // RAM read port
    always_comb begin
        ram_re    = i_cmd.rd_first | i_cmd.scan_adv | i_cmd.m_first | i_cmd.m_adv;
        ram_raddr = '0;
        if (i_cmd.scan_adv || i_cmd.m_first) begin
            ram_raddr = next_g[G_W-1:0];
        end else if (i_cmd.m_adv) begin
            ram_raddr = next_n[G_W-1:0];
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= i_action;
            r_need   <= n_sum[12:4];
            r_addr   <= i_free_addr;
        end
    end

    // walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first) begin
            r_g <= '0;
        end else if (i_cmd.scan_adv) begin
            r_g <= next_g[G_W-1:0];
        end else if (i_cmd.m_adv) begin
            r_g <= r_n;
        end
        if (i_cmd.m_first) begin
            r_n <= next_g[G_W-1:0];
        end else if (i_cmd.m_adv) begin
            r_n <= next_n[G_W-1:0];
        end
        if (i_cmd.m_first || i_cmd.m_adv) begin
            r_cur <= rd;
        end
        if (i_cmd.wr_alloc) begin
            r_split <= r_g + G_W'(r_need);
            r_rest  <= SPAN_W'(rest_full);
        end
    end

    // merge pass flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b0;
        end else if (i_cmd.take) begin
            r_pass <= 1'b0;
        end else if (i_cmd.pass_set) begin
            r_pass <= 1'b1;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ok) begin
            r_res_status <= ST_OK;
            r_res_addr   <= (r_action == ACT_FREE) ? '0 : ADDR_W'(addr_full);
        end else if (i_cmd.res_fail) begin
            r_res_status <= ST_FAIL;
            r_res_addr   <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_user_addr = r_out_addr;

`ifndef NO_ASSERTIONS
    a_no_rw_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && ram_waddr == ram_raddr))
        else $error("header RAM read and write collide");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FAIL) |-> (o_user_addr == '0))
        else $error("failed item carries a nonzero address");

    a_split_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_split |-> (r_rest != '0))
        else $error("split writes an empty remainder");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

`default_nettype wire

[sv/ffba_ctrl.sv]
// ============================================================================
// ffba_ctrl - allocator controller
// One-hot sequencer for search, split, free and the two merge passes.
// ============================================================================
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_SPLIT  = 8'b0000_1000,
        S_MBEGIN = 8'b0001_0000,
        S_MCUR   = 8'b0010_0000,
        S_MNXT   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_INIT: begin
                o_cmd.wr_init = 1'b1;
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (!i_sts.in_free && i_sts.in_big) begin
                        o_cmd.res_fail = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.rd_first = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!i_sts.is_free && i_sts.fit) begin
                    o_cmd.wr_alloc = 1'b1;
                    o_cmd.res_ok   = 1'b1;
                    n_state        = i_sts.split ? S_SPLIT : S_DONE;
                end else if (i_sts.is_free && i_sts.match) begin
                    o_cmd.wr_free = 1'b1;
                    n_state       = S_MBEGIN;
                end else if (i_sts.end_g) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            S_SPLIT: begin
                o_cmd.wr_split = 1'b1;
                n_state        = S_DONE;
            end
            S_MBEGIN: begin
                o_cmd.rd_first = 1'b1;
                n_state        = S_MCUR;
            end
            S_MCUR: begin
                if (i_sts.end_g) begin
                    o_cmd.pass_set = !i_sts.pass_done;
                    o_cmd.res_ok   = i_sts.pass_done;
                    n_state        = i_sts.pass_done ? S_DONE : S_MBEGIN;
                end else begin
                    o_cmd.m_first = 1'b1;
                    n_state       = S_MNXT;
                end
            end
            S_MNXT: begin
                if (i_sts.both_free || i_sts.end_n) begin
                    o_cmd.wr_merge = i_sts.both_free;
                    o_cmd.pass_set = !i_sts.pass_done;
                    o_cmd.res_ok   = i_sts.pass_done;
                    n_state        = i_sts.pass_done ? S_DONE : S_MBEGIN;
                end else begin
                    o_cmd.m_adv = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (r_state != S_IDLE))
        else $error("item taken without leaving idle");

    a_split_after_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_split |-> $past(o_cmd.wr_alloc))
        else $error("remainder written without an allocation");

    a_merge_after_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MBEGIN && !i_sts.pass_done) |-> $past(o_cmd.wr_free))
        else $error("merge pass started without a free");
`endif

endmodule

`default_nettype wire

[sv/first_fit_block_allocator_top.sv]
// Sequence: an allocate walks the headers in S_SCAN, one block per cycle, and writes any
// split remainder in S_SPLIT; an oversized size goes straight to S_DONE with a failure.
// Free: the same search, then two merge passes that each join at most one free pair.
// Throughput: one item at a time, paced by the RAM read port that steps the header walk; the
// next item is taken in the cycle the result turns valid, a result held by the sink waits in
// place. Reset: sync; the heap is built in the S_INIT state that follows it.
// ============================================================================
// first_fit_block_allocator_top - first-fit heap block allocator
// Allocates and frees blocks in an implicit header list held in RAM.
// ============================================================================
`default_nettype none

module first_fit_block_allocator_top
    import ffba_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    // header store and arithmetic
    ffba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_req.action),
        .i_req_size  (i_req.req_size),
        .i_free_addr (i_req.free_addr),
        .i_out_ready (o_rsp.ready),
        .o_sts       (sts),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_user_addr (o_rsp.user_addr)
    );

endmodule

`default_nettype wire

[test/first_fit_block_allocator_top_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// first_fit_block_allocator_top_tb - self-checking bench for the heap allocator
// Drives allocate and free items through the request channel. A shadow copy of
// the header list predicts each untyped row's reply; replies are compared field
// by field as they leave the response channel. Both channels idle at random.
// ============================================================================

module first_fit_block_allocator_top_tb;
    import ffba_pkg::*;

    localparam int unsigned GRAN_B      = 16;      // bytes per granule
    localparam int unsigned HDR_B       = 8;       // header bytes
    localparam int unsigned USED_MARK   = 1;       // allocated bit in a size word
    localparam int          RANDOM_REQS = 1700;
    localparam int          SETTLE_CYC  = 800;

    // One directed row; typed rows carry the reply read off by hand
    typedef struct packed {
        logic              act;
        logic [REQ_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        logic              st;
        logic [ADDR_W-1:0] ua;
    } t_stim_row;

    // One reply still owed by the block
    typedef struct packed {
        logic              act;
        logic [ADDR_W-1:0] arg;
        logic              st;
        logic [ADDR_W-1:0] ua;
    } t_reply;

    // Hand-checked opening sequence, then rows left to the shadow heap
    localparam t_stim_row DIRECTED_ROWS [26] = '{
        '{ACT_ALLOC, 12'd0,    12'd0,    1'b1, ST_OK,   12'd8},     // first grant at base
        '{ACT_ALLOC, 12'd4089, 12'd0,    1'b1, ST_FAIL, 12'd0},     // just over the cap
        '{ACT_ALLOC, 12'd4095, 12'd0,    1'b1, ST_FAIL, 12'd0},     // all ones
        '{ACT_ALLOC, 12'd4088, 12'd0,    1'b1, ST_FAIL, 12'd0},     // max, but no room
        '{ACT_FREE,  12'd0,    12'd4095, 1'b1, ST_FAIL, 12'd0},     // unknown address
        '{ACT_FREE,  12'd0,    12'd0,    1'b1, ST_FAIL, 12'd0},     // header, not payload
        '{ACT_FREE,  12'd0,    12'd8,    1'b1, ST_OK,   12'd0},     // heap merges back
        '{ACT_ALLOC, 12'd4088, 12'd0,    1'b1, ST_OK,   12'd8},     // whole heap, no split
        '{ACT_ALLOC, 12'd0,    12'd0,    1'b1, ST_FAIL, 12'd0},     // heap full
        '{ACT_FREE,  12'd0,    12'd8,    1'b1, ST_OK,   12'd0},
        '{ACT_FREE,  12'd0,    12'd8,    1'b1, ST_OK,   12'd0},     // release of a free block
        '{ACT_ALLOC, 12'd4072, 12'd0,    1'b1, ST_OK,   12'd8},     // leaves one granule
        '{ACT_ALLOC, 12'd0,    12'd0,    1'b1, ST_OK,   12'd4088},  // last granule
        '{ACT_ALLOC, 12'd1,    12'd0,    1'b1, ST_FAIL, 12'd0},
        '{ACT_FREE,  12'd0,    12'd4088, 1'b1, ST_OK,   12'd0},
        '{ACT_FREE,  12'd0,    12'd8,    1'b1, ST_OK,   12'd0},
        '{ACT_ALLOC, 12'd100,  12'd0,    1'b0, ST_OK,   12'd0},
        '{ACT_ALLOC, 12'd7,    12'd0,    1'b0, ST_OK,   12'd0},
        '{ACT_ALLOC, 12'd8,    12'd0,    1'b0, ST_OK,   12'd0},     // exact granule fit
        '{ACT_ALLOC, 12'd9,    12'd0,    1'b0, ST_OK,   12'd0},
        '{ACT_FREE,  12'd0,    12'd120,  1'b0, ST_OK,   12'd0},     // hole between used blocks
        '{ACT_ALLOC, 12'd0,    12'd0,    1'b0, ST_OK,   12'd0},     // refills the hole
        '{ACT_FREE,  12'd0,    12'd136,  1'b0, ST_OK,   12'd0},
        '{ACT_FREE,  12'd0,    12'd152,  1'b0, ST_OK,   12'd0},     // needs both merge passes
        '{ACT_FREE,  12'd0,    12'd1000, 1'b0, ST_OK,   12'd0},
        '{ACT_ALLOC, 12'd2730, 12'd0,    1'b0, ST_OK,   12'd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    // Shadow heap: size in bytes plus allocated bit, per granule
    int unsigned heap_word [HEAP_GRANULES];
    t_reply      awaited_replies [$];
    logic [ADDR_W-1:0] granted_addrs [$];
    bit          quiet = 1'b0;          // no idling on either side while set
    int          fault_cnt = 0;
    int          n_grant = 0, n_refuse = 0, n_release = 0, n_reject = 0, n_checked = 0;

    // Start of the block after the one at g; HEAP_GRANULES ends the walk
    function automatic int unsigned next_start(int unsigned g);
        int unsigned span;
        span = (heap_word[g] & ~USED_MARK) / GRAN_B;
        if (span == 0 || span > HEAP_GRANULES - g)
            return HEAP_GRANULES;
        return g + span;
    endfunction

    // Join the first free block that is followed by a free block
    function automatic void join_free_pair();
        int unsigned g;
        int unsigned n;
        g = 0;
        while (g < HEAP_GRANULES) begin
            n = next_start(g);
            if (n >= HEAP_GRANULES)
                return;
            if (heap_word[g][0] == 1'b0 && heap_word[n][0] == 1'b0) begin
                heap_word[g] = (heap_word[g] & ~USED_MARK) + (heap_word[n] & ~USED_MARK);
                return;
            end
            g = n;
        end
    endfunction

    // Apply one request to the shadow heap and work out its reply
    function automatic void heap_apply_request(input logic act, input logic [REQ_W-1:0] sz,
                                               input logic [ADDR_W-1:0] ad,
                                               output logic st, output logic [ADDR_W-1:0] ua);
        int unsigned g;
        int unsigned w;
        int unsigned want;
        int unsigned need;
        int unsigned rest;
        st = ST_FAIL;
        ua = '0;
        g  = 0;
        if (act == ACT_ALLOC) begin
            want = sz + HDR_B;
            need = (want + GRAN_B - 1) & ~(GRAN_B - 1);
            if (sz > REQ_MAX)
                return;
            while (g < HEAP_GRANULES) begin
                w = heap_word[g];
                if (w[0] == 1'b0 && (w & ~USED_MARK) >= want) begin
                    rest = (w & ~USED_MARK) - need;
                    if (rest >= GRAN_B) begin
                        heap_word[g] = need | USED_MARK;
                        heap_word[g + need / GRAN_B] = rest;
                    end else begin
                        heap_word[g] = w | USED_MARK;
                    end
                    st = ST_OK;
                    ua = ADDR_W'(g * GRAN_B + HDR_B);
                    return;
                end
                g = next_start(g);
            end
        end else begin
            while (g < HEAP_GRANULES && g * GRAN_B + HDR_B != ad)
                g = next_start(g);
            if (g >= HEAP_GRANULES)
                return;
            heap_word[g] = heap_word[g] & ~USED_MARK;
            join_free_pair();
            join_free_pair();
            st = ST_OK;
        end
    endfunction

    // Predict, queue the reply, then hand the item over after a random gap
    task automatic issue_request(input logic act, input logic [REQ_W-1:0] sz,
                                 input logic [ADDR_W-1:0] ad, input logic typed,
                                 input logic tst, input logic [ADDR_W-1:0] tua,
                                 output logic pst, output logic [ADDR_W-1:0] pua);
        int     gap;
        t_reply r;
        gap = quiet ? 0 : $urandom_range(0, 7);
        heap_apply_request(act, sz, ad, pst, pua);
        if (act == ACT_ALLOC) begin
            if (pst == ST_OK) n_grant++; else n_refuse++;
        end else begin
            if (pst == ST_OK) n_release++; else n_reject++;
        end
        r.act = act;
        r.arg = (act == ACT_ALLOC) ? sz : ad;
        r.st  = typed ? tst : pst;
        r.ua  = typed ? tua : pua;
        awaited_replies.push_back(r);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.req_size  <= sz;
        req_ch.free_addr <= ad;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Hold the sender until every reply is back
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    // Reply side: random back-pressure and the field checks
    initial begin
        int     stall;
        t_reply exp_r;
        rsp_ch.ready <= 1'b0;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall == 0) begin
                rsp_ch.ready <= 1'b1;
                do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            end else begin
                rsp_ch.ready <= 1'b0;
                do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
                repeat (stall - 1) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
                do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            end
            if (awaited_replies.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("ERROR: reply with none owed: status=%0d user_addr=%0d",
                             rsp_ch.status, rsp_ch.user_addr);
            end else begin
                exp_r = awaited_replies.pop_front();
                n_checked++;
                if (rsp_ch.status !== exp_r.st || rsp_ch.user_addr !== exp_r.ua) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("ERROR: %s %0d: status exp %0d got %0d, user_addr exp %0d got %0d",
                                 (exp_r.act == ACT_ALLOC) ? "alloc" : "free", exp_r.arg,
                                 exp_r.st, rsp_ch.status, exp_r.ua, rsp_ch.user_addr);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #80_000_000;
        $display("FAIL first_fit_block_allocator_top");
        $finish;
    end

    // Main sequence
    initial begin
        int                sel;
        int                idx;
        logic              act;
        logic [REQ_W-1:0]  sz;
        logic [ADDR_W-1:0] ad;
        logic              pst;
        logic [ADDR_W-1:0] pua;

        req_ch.valid     <= 1'b0;
        req_ch.action    <= ACT_ALLOC;
        req_ch.req_size  <= '0;
        req_ch.free_addr <= '0;
        foreach (heap_word[i]) heap_word[i] = 0;
        heap_word[0] = HEAP_GRANULES * GRAN_B;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED_ROWS[i]) begin
            issue_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].size, DIRECTED_ROWS[i].addr,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].ua,
                          pst, pua);
            if (DIRECTED_ROWS[i].act == ACT_ALLOC && pst == ST_OK)
                granted_addrs.push_back(pua);
        end
        drain_replies();

        // Random traffic: mostly alloc/free of live blocks, some noise
        for (int r = 0; r < RANDOM_REQS; r++) begin
            if (r % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (r % 250 == 249)
                drain_replies();
            sel = $urandom_range(0, 99);
            if (granted_addrs.size() > 40 && sel < 45)
                sel = sel + 40;           // lean toward releases when crowded
            ad = '0;
            sz = '0;
            if (sel < 45) begin
                act = ACT_ALLOC;
                idx = $urandom_range(0, 9);
                if (idx < 7)      sz = REQ_W'($urandom_range(0, 127));
                else if (idx < 9) sz = REQ_W'($urandom_range(128, 1023));
                else              sz = REQ_W'($urandom_range(0, 4095));
            end else if (sel < 87 && granted_addrs.size() != 0) begin
                act = ACT_FREE;
                idx = $urandom_range(0, granted_addrs.size() - 1);
                ad  = granted_addrs[idx];
                if ($urandom_range(0, 99) < 85)
                    granted_addrs.delete(idx);   // else it may be released again later
            end else if (sel < 94) begin
                act = ACT_FREE;
                ad  = ADDR_W'($urandom_range(0, 4095));
            end else begin
                act = ACT_ALLOC;
                sz  = REQ_W'($urandom_range(0, 4095));
            end
            issue_request(act, sz, ad, 1'b0, ST_OK, '0, pst, pua);
            if (act == ACT_ALLOC && pst == ST_OK)
                granted_addrs.push_back(pua);
        end
        req_ch.valid <= 1'b0;

        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Ran %0d requests, %0d replies checked, %0d mismatches",
                 26 + RANDOM_REQS, n_checked, fault_cnt);
        $display("Grants %0d, refused allocs %0d, releases %0d, rejected releases %0d",
                 n_grant, n_refuse, n_release, n_reject);
        if (fault_cnt == 0) begin
            $display("PASS first_fit_block_allocator_top");
        end else begin
            $display("FAIL first_fit_block_allocator_top");
        end
        $finish;
    end

endmodule

[files.f]
sv/ffba_pkg.sv
sv/ffba_req_if.sv
sv/ffba_rsp_if.sv
sv/ffba_ram.sv
sv/ffba_dp.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator_top.sv
test/first_fit_block_allocator_top_tb.sv
